// ===== hw/rtl/xor_linear_basis_core_assert.svh =====
// ---------------------------------------------------------------------------
// xor_linear_basis_core_assert.svh
// Assertion macros used by the checker of the basis core.
// ---------------------------------------------------------------------------
`ifndef XOR_LINEAR_BASIS_CORE_ASSERT_SVH
`define XOR_LINEAR_BASIS_CORE_ASSERT_SVH

// Same-cycle implication, gated by reset.
`define XLB_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("xlb check failed");

// Next-cycle implication, gated by reset.
`define XLB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("xlb check failed");

`endif

// ===== hw/rtl/xlb_pkg.sv =====
// ---------------------------------------------------------------------------
// xlb_pkg
// Shared types, constants and helpers of the GF(2) linear basis core.
// ---------------------------------------------------------------------------
package xlb_pkg;

    localparam int BITS   = 32;
    localparam int WORD_W = 32;
    localparam int IDX_W  = (BITS > 1) ? $clog2(BITS) : 1;
    localparam int EXT_W  = (BITS > WORD_W) ? BITS : WORD_W;

    typedef logic [BITS-1:0]   vec_t;
    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [WORD_W-1:0] word_t;

    typedef enum logic [1:0] {
        MODE_INSERT = 2'd0,
        MODE_TEST   = 2'd1,
        MODE_CLEAR  = 2'd2,
        MODE_SPARE  = 2'd3
    } mode_t;

    typedef struct packed {
        vec_t acc;
        logic slot_nz;
        logic free_hit;
    } step_res_t;

    function automatic vec_t word_to_vec(input word_t w);
        logic [EXT_W-1:0] ext;
        ext = EXT_W'(w);
        return ext[BITS-1:0];
    endfunction

    function automatic word_t vec_to_word(input vec_t v);
        logic [EXT_W-1:0] ext;
        ext = EXT_W'(v);
        return ext[WORD_W-1:0];
    endfunction

endpackage

// ===== hw/rtl/xlb_step_unit.sv =====
// ---------------------------------------------------------------------------
// xlb_step_unit
// Shared XOR step: one slot against the running vector, for both walks.
// ---------------------------------------------------------------------------
module xlb_step_unit (
    input  logic             phase_max,
    input  xlb_pkg::idx_t    bit_idx,
    input  xlb_pkg::vec_t    slot_word,
    input  xlb_pkg::vec_t    acc,
    output xlb_pkg::step_res_t res
);
    import xlb_pkg::*;

    logic bit_set;
    logic slot_nz;
    logic flip;

    always_comb
    begin
        bit_set = acc[bit_idx];
        slot_nz = (slot_word != '0);
        // reduce: cancel a set bit; max: greedily set a clear bit
        flip    = phase_max ? (slot_nz & ~bit_set) : bit_set;
        res.acc      = flip ? (acc ^ slot_word) : acc;
        res.slot_nz  = slot_nz;
        res.free_hit = bit_set & ~slot_nz;
    end

endmodule

// ===== hw/rtl/xor_linear_basis_core.sv =====
// ---------------------------------------------------------------------------
// xor_linear_basis_core
// GF(2) linear basis, one slot per leading bit, insert / test / clear.
// ---------------------------------------------------------------------------
// Input channel (in_valid/in_ready, mode, value): one transfer per operation.
// Output channel (out_valid/out_ready): independent, span_min, span_max.
// One XOR step unit is shared by two walks over the slots, one slot a cycle:
// a reduction walk from the top slot down (insert and test), then a walk that
// forms the span maximum and picks the lowest occupied slot as span_min.
// Insert and test run the reduction walk (ST_RED), then the span walk (ST_MAX)
// and ST_DONE before out_valid is set; clear skips the reduction.
// in_ready is low while an operation is in flight, until ST_DONE hands it off.
// A result waiting on out_ready does not block the next input transfer;
// the following result is held until the output is free.
// Reset empties the basis at once and leaves the block ready.
// ---------------------------------------------------------------------------
module xor_linear_basis_core (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [1:0]            mode,
    input  xlb_pkg::word_t        value,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  independent,
    output xlb_pkg::word_t        span_min,
    output xlb_pkg::word_t        span_max
);
    import xlb_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_RED  = 4'b0010,
        ST_MAX  = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    state_t    state_reg, state_next;
    idx_t      idx_reg, idx_next;
    mode_t     mode_reg, mode_next;
    vec_t      acc_reg, acc_next;
    vec_t      min_reg, min_next;
    idx_t      lead_reg, lead_next;
    logic      found_reg, found_next;
    logic      out_valid_reg, out_valid_next;
    logic      indep_reg;
    word_t     span_min_reg;
    word_t     span_max_reg;
    vec_t      slot_reg [BITS];

    vec_t      slot_rd;
    step_res_t step;
    logic      in_xfer;
    logic      last_idx;
    logic      found_now;
    idx_t      lead_now;
    logic      do_insert;
    logic      do_clear;
    logic      load_out;

    assign in_ready    = (state_reg == ST_IDLE);
    assign in_xfer     = in_valid & in_ready;
    assign out_valid   = out_valid_reg;
    assign independent = indep_reg;
    assign span_min    = span_min_reg;
    assign span_max    = span_max_reg;

    assign slot_rd  = slot_reg[idx_reg];
    assign last_idx = (idx_reg == '0);

    xlb_step_unit u_step (
        .phase_max (state_reg == ST_MAX),
        .bit_idx   (idx_reg),
        .slot_word (slot_rd),
        .acc       (acc_reg),
        .res       (step)
    );

    assign found_now = found_reg | step.free_hit;
    assign lead_now  = found_reg ? lead_reg : idx_reg;
    assign do_insert = (state_reg == ST_RED) & last_idx & found_now &
                       (mode_reg == MODE_INSERT);
    assign do_clear  = in_xfer & (mode_t'(mode) == MODE_CLEAR);
    assign load_out  = (state_reg == ST_DONE) & (~out_valid_reg | out_ready);

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        mode_next      = mode_reg;
        acc_next       = acc_reg;
        min_next       = min_reg;
        lead_next      = lead_reg;
        found_next     = found_reg;
        out_valid_next = out_valid_reg & ~out_ready;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    mode_next  = mode_t'(mode);
                    idx_next   = idx_t'(BITS - 1);
                    found_next = 1'b0;
                    min_next   = '0;
                    if (mode_t'(mode) == MODE_CLEAR)
                    begin
                        acc_next   = '0;
                        state_next = ST_MAX;
                    end
                    else
                    begin
                        acc_next   = word_to_vec(value);
                        state_next = ST_RED;
                    end
                end
            end
            ST_RED:
            begin
                acc_next   = step.acc;
                found_next = found_now;
                lead_next  = lead_now;
                if (last_idx)
                begin
                    acc_next   = '0;
                    idx_next   = idx_t'(BITS - 1);
                    state_next = ST_MAX;
                end
                else
                begin
                    idx_next = idx_reg - 1'b1;
                end
            end
            ST_MAX:
            begin
                acc_next = step.acc;
                if (step.slot_nz)
                begin
                    min_next = slot_rd;
                end
                if (last_idx)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    idx_next = idx_reg - 1'b1;
                end
            end
            ST_DONE:
            begin
                if (load_out)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        mode_reg <= mode_next;
        acc_reg  <= acc_next;
        min_reg  <= min_next;
        lead_reg <= lead_next;
        if (load_out)
        begin
            indep_reg    <= found_reg;
            span_min_reg <= vec_to_word(min_reg);
            span_max_reg <= vec_to_word(acc_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < BITS; i++)
            begin
                slot_reg[i] <= '0;
            end
        end
        else if (do_clear)
        begin
            for (int i = 0; i < BITS; i++)
            begin
                slot_reg[i] <= '0;
            end
        end
        else if (do_insert)
        begin
            slot_reg[lead_now] <= step.acc;
        end
    end

endmodule

// ===== hw/rtl/xlb_checker.sv =====
// ---------------------------------------------------------------------------
// xlb_checker
// Port-level checks of the basis core, bound to the top level.
// ---------------------------------------------------------------------------
`include "xor_linear_basis_core_assert.svh"

module xlb_checker (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_ready,
    input logic [1:0]            mode,
    input xlb_pkg::word_t        value,
    input logic                  out_valid,
    input logic                  out_ready,
    input logic                  independent,
    input xlb_pkg::word_t        span_min,
    input xlb_pkg::word_t        span_max
);
    import xlb_pkg::*;

    logic        in_wait;
    logic        out_wait;
    logic        empty_match;
    logic [33:0] in_word;
    logic [64:0] out_word;

    assign in_wait     = in_valid && !in_ready;
    assign out_wait    = out_valid && !out_ready;
    assign empty_match = ((span_min == '0) == (span_max == '0));
    assign in_word     = {mode, value};
    assign out_word    = {independent, span_min, span_max};

    `XLB_ASSERT_NEXT(a_busy_after_in, clk, rst_n, in_valid && in_ready, !in_ready)
    `XLB_ASSERT_IMPLY(a_span_empty_match, clk, rst_n, out_valid, empty_match)
    `XLB_ASSERT_IMPLY(a_span_order, clk, rst_n, out_valid, span_min <= span_max)
    `XLB_ASSERT_NEXT(a_in_hold, clk, rst_n, in_wait, in_valid && $stable(in_word))
    `XLB_ASSERT_NEXT(a_out_hold, clk, rst_n, out_wait, out_valid && $stable(out_word))

endmodule

bind xor_linear_basis_core xlb_checker u_xlb_checker (.*);
